>>> rtl/core/mtst_pkg.sv
// shared types and constants of the motion to step tap quantizer
`default_nettype none

package mtst_pkg;

    localparam int MAX_TAPS_DEF = 10;

    localparam int TYPE_W  = 16;
    localparam int CODE_W  = 16;
    localparam int VALUE_W = 16;
    localparam int THR_W   = 15;
    localparam int SUM_W   = 16;
    localparam int WORK_W  = SUM_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_USER_W  = TYPE_W + CODE_W;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 2;

    localparam logic [TYPE_W-1:0] MATCH_TYPE_RST = TYPE_W'(2);
    localparam logic [CODE_W-1:0] MATCH_CODE_RST = CODE_W'(0);
    localparam logic [THR_W-1:0]  THRESHOLD_RST  = THR_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MATCH_TYPE = 2'd0,
        REG_MATCH_CODE = 2'd1,
        REG_THRESHOLD  = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_STEP
    } state_t;

endpackage

`default_nettype wire

>>> rtl/core/motion_to_step_taps.sv
// top level: quantizes relative motion on one axis into forward and back taps
`default_nettype none

// One event is taken at a time. An event that does not match the configured type and
// code gives one pass-through result, registered after the accumulate state, and then the
// block returns to idle for the next event. A matching event is added to the residue, then
// one shared 17-bit adder takes one threshold step per cycle, up to MAX_TAPS steps, while
// the result side does not stall. Results come one per cycle, while the result side does
// not stall, out of an output register; the last result of each event carries tlast.
// Configuration writes are always taken and should only be made while the block is idle.
module motion_to_step_taps
    import mtst_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    // event_value
    input  wire [VALUE_W-1:0]     s_tdata,
    // event_type [15:0], event_code [31:16]
    input  wire [IN_USER_W-1:0]   s_tuser,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    // tap_direction [0], zero fill above
    output logic [OUT_DATA_W-1:0] m_tdata,
    // tap_valid [0], consumed [1]
    output logic [OUT_USER_W-1:0] m_tuser,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data
);

    localparam int TAP_CNT_W = $clog2(MAX_TAPS + 1);

    state_t state_reg, state_next;

    logic [TYPE_W-1:0]  match_type_reg;
    logic [CODE_W-1:0]  match_code_reg;
    logic [THR_W-1:0]   threshold_reg;

    logic [TYPE_W-1:0]  ev_type_reg;
    logic [CODE_W-1:0]  ev_code_reg;
    logic [VALUE_W-1:0] ev_value_reg;

    logic signed [SUM_W-1:0]  motion_sum_reg, motion_sum_next;
    logic signed [WORK_W-1:0] work_reg, work_next;
    logic [TAP_CNT_W-1:0]     taps_reg, taps_next;
    logic                     dir_reg, dir_next;
    logic                     pend_reg, pend_next;

    logic out_valid_reg, out_valid_next;
    logic out_dir_reg, out_dir_next;
    logic out_tap_reg, out_tap_next;
    logic out_cons_reg, out_cons_next;
    logic out_last_reg, out_last_next;

    logic [THR_W-1:0]         thr_eff;
    logic signed [WORK_W-1:0] thr_ext;
    logic signed [WORK_W-1:0] add_a, add_b, add_res;
    logic signed [WORK_W-1:0] clamp_val;
    logic                     ev_match;
    logic                     step_cond;
    logic                     can_step;
    logic                     out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OUT_DATA_W-1){1'b0}}, out_dir_reg};
    assign m_tuser   = {out_cons_reg, out_tap_reg};
    assign m_tlast   = out_last_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign thr_eff  = (threshold_reg == '0) ? THR_W'(1) : threshold_reg;
    assign thr_ext  = signed'({{(WORK_W-THR_W){1'b0}}, thr_eff});
    assign ev_match = (ev_type_reg == match_type_reg) && (ev_code_reg == match_code_reg);

    // the one shared adder: accumulate, then threshold steps
    always_comb
    begin
        if (state_reg == ST_STEP)
        begin
            add_a = work_reg;
            add_b = dir_reg ? thr_ext : -thr_ext;
        end
        else
        begin
            add_a = WORK_W'(motion_sum_reg);
            add_b = WORK_W'(signed'(ev_value_reg));
        end
    end
    assign add_res = add_a + add_b;

    // forward step while sum - thr >= 0, back step while sum + thr <= 0
    assign step_cond = dir_reg ? (add_res <= 0) : !add_res[WORK_W-1];
    assign can_step  = step_cond && (taps_reg != TAP_CNT_W'(MAX_TAPS));
    assign clamp_val = dir_reg ? (WORK_W'(1) - thr_ext) : (thr_ext - WORK_W'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                if (ev_match)
                begin
                    state_next = ST_STEP;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_STEP:
            begin
                if (!can_step && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        motion_sum_next = motion_sum_reg;
        work_next       = work_reg;
        taps_next       = taps_reg;
        dir_next        = dir_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_dir_next    = out_dir_reg;
        out_tap_next    = out_tap_reg;
        out_cons_next   = out_cons_reg;
        out_last_next   = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_ACCUM:
            begin
                if (ev_match)
                begin
                    work_next = add_res;
                    dir_next  = add_res[WORK_W-1];
                    taps_next = '0;
                    pend_next = 1'b0;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_dir_next   = 1'b0;
                    out_tap_next   = 1'b0;
                    out_cons_next  = 1'b0;
                    out_last_next  = 1'b1;
                end
            end
            ST_STEP:
            begin
                if (can_step)
                begin
                    // a held tap goes out only once the next step is known to exist
                    if (!pend_reg || out_free)
                    begin
                        work_next = add_res;
                        taps_next = taps_reg + TAP_CNT_W'(1);
                        pend_next = 1'b1;
                        if (pend_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_dir_next   = dir_reg;
                            out_tap_next   = 1'b1;
                            out_cons_next  = 1'b1;
                            out_last_next  = 1'b0;
                        end
                    end
                end
                else if (out_free)
                begin
                    // steps done: keep the residue, or clamp it if the tap limit hit with a full step left
                    motion_sum_next = step_cond ? clamp_val[SUM_W-1:0] : work_reg[SUM_W-1:0];
                    pend_next       = 1'b0;
                    out_valid_next  = 1'b1;
                    out_dir_next    = pend_reg && dir_reg;
                    out_tap_next    = pend_reg;
                    out_cons_next   = 1'b1;
                    out_last_next   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            match_type_reg <= MATCH_TYPE_RST;
            match_code_reg <= MATCH_CODE_RST;
            threshold_reg  <= THRESHOLD_RST;
            motion_sum_reg <= '0;
            taps_reg       <= '0;
            dir_reg        <= 1'b0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            motion_sum_reg <= motion_sum_next;
            taps_reg       <= taps_next;
            dir_reg        <= dir_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_MATCH_TYPE: match_type_reg <= cfg_data[TYPE_W-1:0];
                    REG_MATCH_CODE: match_code_reg <= cfg_data[CODE_W-1:0];
                    REG_THRESHOLD:  threshold_reg  <= cfg_data[THR_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ev_type_reg  <= s_tuser[TYPE_W-1:0];
            ev_code_reg  <= s_tuser[IN_USER_W-1:TYPE_W];
            ev_value_reg <= s_tdata;
        end
        work_reg      <= work_next;
        out_dir_reg   <= out_dir_next;
        out_tap_reg   <= out_tap_next;
        out_cons_reg  <= out_cons_next;
        out_last_reg  <= out_last_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/mtst_checker.sv
// port-level checks of the motion to step tap quantizer, bound to the top level
`default_nettype none

module mtst_checker
    import mtst_pkg::*;
(
    input wire                  clk,
    input wire                  rst_n,
    input wire                  s_tvalid,
    input wire                  s_tready,
    input wire [OUT_DATA_W-1:0] m_tdata,
    input wire [OUT_USER_W-1:0] m_tuser,
    input wire                  m_tlast,
    input wire                  m_tvalid,
    input wire                  m_tready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // a result that is not a tap always carries tlast and a zero direction
    a_notap_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && !m_tdata[0])
        else $error("non-tap result without tlast");

    // taps only come from consumed events
    a_tap_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[1])
        else $error("tap from an unconsumed event");

    // one event at a time: no second transfer right after one
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

endmodule

bind motion_to_step_taps mtst_checker u_mtst_checker (.*);

`default_nettype wire
